// ===== rtl/dithered_time_proportional_outputs_core_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the dithered time-proportional output driver
// every check is sampled at the rising clock edge, quiet while reset is low
// ----------------------------------------------------------------------------
`ifndef DITHERED_TIME_PROPORTIONAL_OUTPUTS_CORE_ASSERT_SVH
`define DITHERED_TIME_PROPORTIONAL_OUTPUTS_CORE_ASSERT_SVH

// expression holds on every edge out of reset
`define DTPO_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// consequent holds in the cycle after the antecedent
`define DTPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");

`endif

// ===== rtl/dtpo_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpo_pkg
// shared constants, types and the power-setting decoder of the output driver
// ----------------------------------------------------------------------------
`default_nettype none

package dtpo_pkg;

    localparam int CHANNELS       = 8;
    localparam int NUM_REGS       = 8;
    localparam int PERIOD_TICKS   = 100;
    localparam int DITHER_PERIODS = 10;

    localparam int POWER_W = 10;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 8;
    localparam int WHOLE_W = 7;
    localparam int TENTH_W = 4;
    localparam int ETC_W   = 4;
    localparam int TICK_W  = $clog2(PERIOD_TICKS + 1);
    localparam int PIDX_W  = $clog2(DITHER_PERIODS);
    localparam int CMP_W   = ((TICK_W > WHOLE_W) ? TICK_W : WHOLE_W) + 1;
    localparam int PROD_W  = 8;

    localparam int FULL_POWER = 1000;
    localparam int TENTHS     = 10;

    // x / 10 == (x * 205) >> 11 for every 10-bit x
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DIV10_PW    = POWER_W + 8;

    localparam logic [ETC_W-1:0]  ETC_MAX   = '1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(PERIOD_TICKS);
    localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(DITHER_PERIODS - 1);

    // decoded power setting of one channel
    typedef struct packed {
        logic               full;
        logic               zero;
        logic [WHOLE_W-1:0] whole;
        logic [TENTH_W-1:0] tenth;
    } chan_cfg_t;

    // per-tick timing shared by all channels
    typedef struct packed {
        logic [TICK_W-1:0] elapsed;
        logic [PIDX_W-1:0] pidx;
        logic              restart;
        logic              clear;
    } tick_ctx_t;

    function automatic chan_cfg_t decode_power(input logic [POWER_W-1:0] p);
        logic [DIV10_PW-1:0] prod;
        logic [WHOLE_W-1:0]  whole;
        logic [POWER_W-1:0]  rem;
        chan_cfg_t           c;
        prod    = DIV10_PW'(p) * DIV10_PW'(DIV10_MUL);
        whole   = WHOLE_W'(prod >> DIV10_SHIFT);
        rem     = p - POWER_W'(POWER_W'(whole) * POWER_W'(TENTHS));
        c.full  = (p >= POWER_W'(FULL_POWER));
        c.zero  = (p == '0);
        c.whole = whole;
        c.tenth = rem[TENTH_W-1:0];
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtpo_cfg.sv =====
// ----------------------------------------------------------------------------
// dtpo_cfg
// power registers, kept already split into whole ticks and tenths
// ----------------------------------------------------------------------------
`default_nettype none

module dtpo_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [dtpo_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [dtpo_pkg::POWER_W-1:0]   cfg_wdata,
    output dtpo_pkg::chan_cfg_t                 chan_cfg [dtpo_pkg::NUM_REGS]
);
    import dtpo_pkg::*;

    chan_cfg_t cfg_reg [NUM_REGS];
    chan_cfg_t wr_dec;

    // decode once at write time so the tick path sees no division
    assign wr_dec = decode_power(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= decode_power(POWER_W'(FULL_POWER));
            end
        end else if (cfg_we) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (cfg_addr == ADDR_W'(i)) begin
                    cfg_reg[i] <= wr_dec;
                end
            end
        end
    end

    assign chan_cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/dtpo_chan.sv =====
// ----------------------------------------------------------------------------
// dtpo_chan
// one output channel: on/off timing and extra-tick dither counter
// ----------------------------------------------------------------------------
`default_nettype none

module dtpo_chan (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire logic                sw,
    input  wire dtpo_pkg::chan_cfg_t cfg,
    input  wire dtpo_pkg::tick_ctx_t ctx,
    output logic                     drive_next
);
    import dtpo_pkg::*;

    logic             drive_reg;
    logic [ETC_W-1:0] etc_reg;
    logic [ETC_W-1:0] etc_next;
    logic [CMP_W-1:0] elapsed_x;
    logic [CMP_W-1:0] whole_x;
    logic [PROD_W-1:0] granted_x10;
    logic [PROD_W-1:0] allowed;
    logic             over_quota;
    logic             d;

    assign elapsed_x   = CMP_W'(ctx.elapsed);
    assign whole_x     = CMP_W'(cfg.whole);
    assign granted_x10 = PROD_W'(etc_reg) * PROD_W'(TENTHS);
    assign allowed     = PROD_W'(cfg.tenth) * PROD_W'(ctx.pidx);
    assign over_quota  = (ctx.pidx != '0) && (granted_x10 > allowed);

    // turn-off, extra tick, period start, full-power follow and dither-counter clear
    always_comb begin
        d        = drive_reg;
        etc_next = etc_reg;
        if (cfg.full) begin
            d = sw;
        end else begin
            if (elapsed_x >= whole_x) begin
                if ((cfg.tenth == '0) || (elapsed_x >= whole_x + CMP_W'(1))) begin
                    d = 1'b0;
                end else if (over_quota) begin
                    d = 1'b0;
                end else if (etc_reg != ETC_MAX) begin
                    etc_next = etc_reg + ETC_W'(1);
                end
            end
            if (ctx.restart && !cfg.zero && sw) begin
                d = 1'b1;
            end
        end
        if (ctx.clear) begin
            etc_next = '0;
        end
    end

    assign drive_next = d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= 1'b0;
            etc_reg   <= '0;
        end else if (advance) begin
            drive_reg <= d;
            etc_reg   <= etc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dithered_time_proportional_outputs_core.sv =====
// ----------------------------------------------------------------------------
// dithered_time_proportional_outputs_core
// eight-channel time-proportioned output driver with tenth-percent dither
// ----------------------------------------------------------------------------
// Each accepted word on s_ is one tick and yields one drive_mask word on m_.
// A word is taken into an input register, then the period counter and the
// per-channel dither counters update in the same cycle as the result is
// written to the output register, and the block sustains one tick per
// clock while the output is not stalled by m_tready; the shared tick/period
// counters feed all eight channel comparators.
// Power registers are written through cfg_we/cfg_addr/cfg_wdata and take
// effect on the next tick; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dithered_time_proportional_outputs_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [dtpo_pkg::ADDR_W-1:0]   cfg_addr,
    input  wire logic [dtpo_pkg::POWER_W-1:0]  cfg_wdata,
    // tick input, tdata: [7:0] switch_mask
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dtpo_pkg::DATA_W-1:0]   s_tdata,
    // result output, tdata: [7:0] drive_mask
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dtpo_pkg::DATA_W-1:0]        m_tdata
);
    import dtpo_pkg::*;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [TICK_W-1:0] ticks_next;
    logic [PIDX_W-1:0] pidx_reg;
    logic [PIDX_W-1:0] pidx_next;
    logic              advance;
    logic              restart;
    tick_ctx_t         ctx;
    chan_cfg_t         chan_cfg [NUM_REGS];
    logic [DATA_W-1:0] drive_next;

    // handshake: compute fires when a word is held and the output can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // period and dither-cycle counters
    assign restart    = (ticks_reg >= TICK_LAST);
    assign pidx_next  = restart ? ((pidx_reg == PIDX_LAST) ? '0 : pidx_reg + PIDX_W'(1))
                                : pidx_reg;
    assign ticks_next = (restart ? '0 : ticks_reg) + TICK_W'(1);

    assign ctx.elapsed = ticks_reg;
    assign ctx.pidx    = pidx_reg;
    assign ctx.restart = restart;
    assign ctx.clear   = restart && (pidx_next == '0);

    dtpo_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .chan_cfg  (chan_cfg)
    );

    // channel lanes, unused mask bits stay low
    for (genvar i = 0; i < DATA_W; i++) begin : g_chan
        if (i < CHANNELS && i < NUM_REGS) begin : g_on
            dtpo_chan u_chan (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .sw         (in_data_reg[i]),
                .cfg        (chan_cfg[i]),
                .ctx        (ctx),
                .drive_next (drive_next[i])
            );
        end else begin : g_off
            assign drive_next[i] = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // tick state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= '0;
            pidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                ticks_reg <= ticks_next;
                pidx_reg  <= pidx_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= drive_next;
        end
    end

`include "dithered_time_proportional_outputs_core_assert.svh"

    `DTPO_ASSERT_ALWAYS(a_ticks_range, aclk, aresetn, ticks_reg <= TICK_LAST)
    `DTPO_ASSERT_ALWAYS(a_pidx_range, aclk, aresetn, pidx_reg <= PIDX_LAST)
    `DTPO_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, out_valid_reg)
    `DTPO_ASSERT_NEXT(a_held_word_kept, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg))

endmodule

`default_nettype wire
